/* hw/rtl/vrpe_pkg.sv */
// shared types, constants and helpers for the voxel ray pick and edit block
package vrpe_pkg;

  // grid and march constants
  localparam int SIZE_X    = 128;
  localparam int HEIGHT    = 64;
  localparam int SIZE_Z    = 128;
  localparam int STEP_Q16  = 3277;
  localparam int MAX_STEPS = 160;
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int CMD_W  = 2;
  localparam int TYPE_W = 8;
  localparam int POS_W  = 26;
  localparam int DIR_W  = 18;
  localparam int EX_W   = 7;
  localparam int EY_W   = 6;
  localparam int EZ_W   = 7;

  // voxel index widths and memory shape
  localparam int X_W       = $clog2(SIZE_X);
  localparam int Y_W       = $clog2(HEIGHT);
  localparam int Z_W       = $clog2(SIZE_Z);
  localparam int ADDR_W    = X_W + Z_W + Y_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  // march datapath widths
  localparam int STEP_W = $clog2(STEP_Q16 + 1) + 1;
  localparam int INC_W  = STEP_W + DIR_W;
  localparam int K_W    = $clog2(MAX_STEPS + 1);
  localparam int ACC_W  = INC_W + K_W;
  localparam int OFS_W  = ACC_W - FRAC_BITS;
  localparam int CUR_W  = ((POS_W > OFS_W) ? POS_W : OFS_W) + 1;
  localparam int VOX_W  = CUR_W - FRAC_BITS;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic signed [INC_W-1:0] inc_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [CUR_W-1:0] cur_t;
  typedef logic signed [VOX_W-1:0] vox_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  typedef struct packed {
    vox_t x;
    vox_t y;
    vox_t z;
  } vcoord_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_RAY   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_MARCH,
    ST_RDWAIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    AX_X,
    AX_Y,
    AX_Z
  } axis_e;

  // control from the sequencer to the ray stepper
  typedef struct packed {
    logic  load;
    logic  mul_en;
    axis_e axis;
    logic  advance;
  } step_ctrl_t;

  typedef struct packed {
    logic [TYPE_W-1:0] rv;
    logic              wr;
    logic [EX_W-1:0]   x;
    logic [EY_W-1:0]   y;
    logic [EZ_W-1:0]   z;
  } res_t;

  function automatic vox_t pos_to_vox(pos_t p);
    pos_t sh;
    sh = p >>> FRAC_BITS;
    return vox_t'(sh);
  endfunction

  function automatic logic in_lim(vox_t a, int lim);
    return !a[VOX_W-1] && ($unsigned(a) < VOX_W'(lim));
  endfunction

  function automatic logic in_grid(vcoord_t v);
    return in_lim(v.x, SIZE_X) && in_lim(v.y, HEIGHT) && in_lim(v.z, SIZE_Z);
  endfunction

  function automatic addr_t addr_of(vcoord_t v);
    return {v.x[X_W-1:0], v.z[Z_W-1:0], v.y[Y_W-1:0]};
  endfunction

  function automatic res_t with_coords(res_t r, vcoord_t v);
    res_t o;
    o   = r;
    o.x = v.x[EX_W-1:0];
    o.y = v.y[EY_W-1:0];
    o.z = v.z[EZ_W-1:0];
    return o;
  endfunction

endpackage

/* hw/rtl/vrpe_if.sv */
// command and result channel interfaces
interface vrpe_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [vrpe_pkg::CMD_W-1:0]      command;
  logic [vrpe_pkg::TYPE_W-1:0]     blk_code;
  logic signed [vrpe_pkg::POS_W-1:0] pos_x;
  logic signed [vrpe_pkg::POS_W-1:0] pos_y;
  logic signed [vrpe_pkg::POS_W-1:0] pos_z;
  logic signed [vrpe_pkg::DIR_W-1:0] dir_x;
  logic signed [vrpe_pkg::DIR_W-1:0] dir_y;
  logic signed [vrpe_pkg::DIR_W-1:0] dir_z;

  modport source (
    output valid, command, blk_code, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, command, blk_code, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

interface vrpe_res_if;
  logic                        valid;
  logic                        ready;
  logic [vrpe_pkg::TYPE_W-1:0] read_value;
  logic                        wrote;
  logic [vrpe_pkg::EX_W-1:0]   edit_x;
  logic [vrpe_pkg::EY_W-1:0]   edit_y;
  logic [vrpe_pkg::EZ_W-1:0]   edit_z;

  modport source (
    output valid, read_value, wrote, edit_x, edit_y, edit_z,
    input  ready
  );
  modport sink (
    input  valid, read_value, wrote, edit_x, edit_y, edit_z,
    output ready
  );
endinterface

/* hw/rtl/vrpe_ray_stepper.sv */
// ray stepper: shared direction scaler and per-axis step accumulators
module vrpe_ray_stepper (
  input  logic                 clk_i,
  input  vrpe_pkg::step_ctrl_t ctrl_i,
  input  vrpe_pkg::pos_t       pos_x_i,
  input  vrpe_pkg::pos_t       pos_y_i,
  input  vrpe_pkg::pos_t       pos_z_i,
  input  vrpe_pkg::dir_t       dir_x_i,
  input  vrpe_pkg::dir_t       dir_y_i,
  input  vrpe_pkg::dir_t       dir_z_i,
  output vrpe_pkg::vcoord_t    vox_o,
  output logic                 vox_ok_o
);
  import vrpe_pkg::*;

  pos_t pos_q [3];
  dir_t dir_q [3];
  inc_t inc_q [3];
  acc_t acc_q [3];
  vox_t vox   [3];
  dir_t dir_sel;
  inc_t prod;

  // one multiplier, one axis per cycle
  always_comb begin
    unique case (ctrl_i.axis)
      AX_X:    dir_sel = dir_q[0];
      AX_Y:    dir_sel = dir_q[1];
      AX_Z:    dir_sel = dir_q[2];
      default: dir_sel = dir_q[0];
    endcase
    prod = inc_t'(dir_sel) * inc_t'(STEP_Q16);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      pos_q[0] <= pos_x_i;
      pos_q[1] <= pos_y_i;
      pos_q[2] <= pos_z_i;
      dir_q[0] <= dir_x_i;
      dir_q[1] <= dir_y_i;
      dir_q[2] <= dir_z_i;
    end
    for (int i = 0; i < 3; i++) begin
      if (ctrl_i.load) begin
        acc_q[i] <= '0;
      end else if (ctrl_i.advance) begin
        acc_q[i] <= acc_q[i] + acc_t'(inc_q[i]);
      end
      if (ctrl_i.mul_en && (ctrl_i.axis == axis_e'(i))) begin
        inc_q[i] <= prod;
      end
    end
  end

  // floor(pos + floor(t*dir)) in voxel units
  always_comb begin
    acc_t ofs;
    cur_t cur;
    for (int i = 0; i < 3; i++) begin
      ofs    = acc_q[i] >>> FRAC_BITS;
      cur    = cur_t'(pos_q[i]) + cur_t'(ofs);
      vox[i] = vox_t'(cur[CUR_W-1:FRAC_BITS]);
    end
  end

  assign vox_o.x  = vox[0];
  assign vox_o.y  = vox[1];
  assign vox_o.z  = vox[2];
  assign vox_ok_o = in_grid(vox_o);

endmodule

/* hw/rtl/voxel_ray_pick_edit.sv */
// voxel ray pick and edit: top level with sequencer, voxel memory and result register
// after accept a write, an unused command or an out-of-grid item goes straight to done, a read
// passes through the read wait state, and a ray edit scales the direction one axis at a time,
// then marches for up to MAX_STEPS steps; one item at a time, and ready returns the cycle the
// result lands in the output register, while the done state holds as long as the output stalls
// after reset the grid is cleared to air, one voxel a cycle, over all 2**ADDR_W addresses
module voxel_ray_pick_edit (
  input  logic       clk_i,
  input  logic       rst_ni,
  vrpe_cmd_if.sink   cmd_i,
  vrpe_res_if.source res_o
);
  import vrpe_pkg::*;

  state_e state_q, state_d;
  addr_t  clr_addr_q;
  axis_e  axis_q, axis_next;
  logic [K_W-1:0] k_q;
  logic   pend_valid_q;
  logic   out_valid_q;

  logic [TYPE_W-1:0] btype_q;
  vcoord_t last_vox_q, pend_vox_q, pend_prev_q;
  res_t    res_q, res_d, out_q;

  logic [TYPE_W-1:0] voxel_mem [MEM_DEPTH];
  logic [TYPE_W-1:0] rd_q;
  logic              mem_we;
  addr_t             mem_waddr, mem_raddr;
  logic [TYPE_W-1:0] mem_wdata;

  step_ctrl_t step_ctrl;
  vcoord_t    step_vox, in_vox, hit_vox;
  logic       step_ok, in_ok;
  cmd_e       in_cmd;
  logic       accept, hit, last, issue, out_free;

  vrpe_ray_stepper u_stepper (
    .clk_i    (clk_i),
    .ctrl_i   (step_ctrl),
    .pos_x_i  (cmd_i.pos_x),
    .pos_y_i  (cmd_i.pos_y),
    .pos_z_i  (cmd_i.pos_z),
    .dir_x_i  (cmd_i.dir_x),
    .dir_y_i  (cmd_i.dir_y),
    .dir_z_i  (cmd_i.dir_z),
    .vox_o    (step_vox),
    .vox_ok_o (step_ok)
  );

  assign in_cmd   = cmd_e'(cmd_i.command);
  assign in_vox.x = pos_to_vox(cmd_i.pos_x);
  assign in_vox.y = pos_to_vox(cmd_i.pos_y);
  assign in_vox.z = pos_to_vox(cmd_i.pos_z);
  assign in_ok    = in_grid(in_vox);

  assign cmd_i.ready = (state_q == ST_IDLE);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;

  // read data of the previous step arrives while the next step is issued
  assign hit     = pend_valid_q && (rd_q != '0);
  assign last    = (k_q == K_W'(MAX_STEPS));
  assign issue   = (state_q == ST_MARCH) && !hit && !last && step_ok;
  assign hit_vox = (btype_q != '0) ? pend_prev_q : pend_vox_q;

  always_comb begin
    unique case (axis_q)
      AX_X:    axis_next = AX_Y;
      AX_Y:    axis_next = AX_Z;
      default: axis_next = AX_X;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_RAY:  state_d = in_ok ? ST_MUL : ST_DONE;
            CMD_READ: state_d = in_ok ? ST_RDWAIT : ST_DONE;
            CMD_WRITE, CMD_NONE: state_d = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        if (axis_q == AX_Z) state_d = ST_MARCH;
      end
      ST_MARCH: begin
        if (hit || last || !step_ok) state_d = ST_DONE;
      end
      ST_RDWAIT: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs: memory port, stepper control, result build-up
  always_comb begin
    mem_we            = 1'b0;
    mem_waddr         = clr_addr_q;
    mem_wdata         = '0;
    mem_raddr         = addr_of(step_vox);
    step_ctrl         = '0;
    step_ctrl.load    = accept;
    step_ctrl.mul_en  = (state_q == ST_MUL);
    step_ctrl.axis    = axis_q;
    step_ctrl.advance = issue;
    res_d             = res_q;
    unique case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          unique case (in_cmd)
            CMD_WRITE: begin
              if (in_ok) begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(in_vox);
                mem_wdata = cmd_i.blk_code;
                res_d.wr  = 1'b1;
                res_d     = with_coords(res_d, in_vox);
              end
            end
            CMD_READ: begin
              if (in_ok) begin
                mem_raddr = addr_of(in_vox);
                res_d     = with_coords(res_d, in_vox);
              end
            end
            CMD_RAY, CMD_NONE: ;
          endcase
        end
      end
      ST_MARCH: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = addr_of(hit_vox);
          mem_wdata = btype_q;
          res_d.wr  = 1'b1;
          res_d     = with_coords(res_d, hit_vox);
        end
      end
      ST_RDWAIT: res_d.rv = rd_q;
      ST_MUL, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      axis_q       <= AX_X;
      k_q          <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (accept) begin
        axis_q       <= AX_X;
        k_q          <= '0;
        pend_valid_q <= 1'b0;
      end else begin
        if (state_q == ST_MUL) axis_q <= axis_next;
        if (issue) begin
          k_q          <= k_q + K_W'(1);
          pend_valid_q <= 1'b1;
        end
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      btype_q    <= cmd_i.blk_code;
      last_vox_q <= in_vox;
    end else if (issue) begin
      last_vox_q <= step_vox;
    end
    if (issue) begin
      pend_vox_q  <= step_vox;
      pend_prev_q <= last_vox_q;
    end
    if ((state_q == ST_DONE) && out_free) out_q <= res_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) voxel_mem[mem_waddr] <= mem_wdata;
    rd_q <= voxel_mem[mem_raddr];
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.read_value = out_q.rv;
  assign res_o.wrote      = out_q.wr;
  assign res_o.edit_x     = out_q.x;
  assign res_o.edit_y     = out_q.y;
  assign res_o.edit_z     = out_q.z;

endmodule

/* hw/rtl/vrpe_checker.sv */
// port-level checks for the voxel ray pick and edit block, bound to the top level
module vrpe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [vrpe_pkg::TYPE_W-1:0] read_value_i,
  input logic                        wrote_i,
  input logic [vrpe_pkg::EX_W-1:0]   edit_x_i,
  input logic [vrpe_pkg::EY_W-1:0]   edit_y_i,
  input logic [vrpe_pkg::EZ_W-1:0]   edit_z_i
);

  // input ready is low in the cycle after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

  // a result never both writes and reports a non-air read
  a_write_or_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(wrote_i && (read_value_i != '0)))
    else $error("result both wrote and read a voxel");

  // a new result only appears while an item was in flight
  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared with no item in flight");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_value_i) &&
      $stable(wrote_i) && $stable(edit_x_i) && $stable(edit_y_i) && $stable(edit_z_i))
    else $error("stalled result changed");

endmodule

bind voxel_ray_pick_edit vrpe_checker u_vrpe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (cmd_i.valid),
  .in_ready_i   (cmd_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .read_value_i (res_o.read_value),
  .wrote_i      (res_o.wrote),
  .edit_x_i     (res_o.edit_x),
  .edit_y_i     (res_o.edit_y),
  .edit_z_i     (res_o.edit_z)
);

/* bench/voxel_ray_pick_edit_tb.sv */
// self-checking testbench for the voxel ray pick and edit block
`timescale 1ns / 100ps

module voxel_ray_pick_edit_tb;
  import vrpe_pkg::*;

  localparam int ONE        = 1 << FRAC_BITS;
  localparam int HALF       = ONE / 2;
  localparam int POS_MAX    = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN    = -(2 ** (POS_W - 1));
  localparam int DIR_MAX    = 2 ** (DIR_W - 1) - 1;
  localparam int DIR_MIN    = -(2 ** (DIR_W - 1));
  localparam int GRID_CELLS = SIZE_X * HEIGHT * SIZE_Z;
  localparam int RAND_ITEMS = 600;
  localparam int DRAIN      = 200;
  localparam int LIMIT      = 4_000_000;
  // dense block region so random rays find something to hit
  localparam int REG_LO     = 40;
  localparam int REG_SPAN   = 24;

  typedef struct {
    cmd_e              command;
    logic [TYPE_W-1:0] blk_code;
    pos_t              pos_x;
    pos_t              pos_y;
    pos_t              pos_z;
    dir_t              dir_x;
    dir_t              dir_y;
    dir_t              dir_z;
    bit                typed;
    res_t              want;
  } stim_t;

  typedef struct {
    int x;
    int y;
    int z;
  } spot_t;

  logic clk_i;
  logic rst_ni;

  vrpe_cmd_if cmd_if ();
  vrpe_res_if res_if ();

  voxel_ray_pick_edit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  logic [TYPE_W-1:0] grid_model [0:GRID_CELLS-1];
  res_t              pending_results [$];
  stim_t             directed_rows [$];
  spot_t             placed_blocks [$];
  int                err_cnt;
  int                cycle_cnt;
  int                src_calm;
  int                snk_calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic bit in_bounds(longint x, longint y, longint z);
    return x >= 0 && y >= 0 && z >= 0 && x < SIZE_X && y < HEIGHT && z < SIZE_Z;
  endfunction

  function automatic int cell_of(longint x, longint y, longint z);
    return int'((x * SIZE_Z + z) * HEIGHT + y);
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // applies one command to the grid copy and returns the result it gives
  function automatic res_t march_and_edit(stim_t s);
    longint px, py, pz, dx, dy, dz;
    longint vx, vy, vz, prx, pry, prz, t;
    res_t   r;
    bit     done;
    int     k;
    px = longint'(s.pos_x);
    py = longint'(s.pos_y);
    pz = longint'(s.pos_z);
    dx = longint'(s.dir_x);
    dy = longint'(s.dir_y);
    dz = longint'(s.dir_z);
    vx = px >>> FRAC_BITS;
    vy = py >>> FRAC_BITS;
    vz = pz >>> FRAC_BITS;
    r  = '0;
    case (s.command)
      CMD_WRITE: begin
        if (in_bounds(vx, vy, vz)) begin
          grid_model[cell_of(vx, vy, vz)] = s.blk_code;
          r.wr = 1'b1;
          r.x  = vx[EX_W-1:0];
          r.y  = vy[EY_W-1:0];
          r.z  = vz[EZ_W-1:0];
        end
      end
      CMD_READ: begin
        if (in_bounds(vx, vy, vz)) begin
          r.rv = grid_model[cell_of(vx, vy, vz)];
          r.x  = vx[EX_W-1:0];
          r.y  = vy[EY_W-1:0];
          r.z  = vz[EZ_W-1:0];
        end
      end
      CMD_RAY: begin
        // start point is checked in fixed point, not by voxel
        if (px >= 0 && py >= 0 && pz >= 0 && px < longint'(SIZE_X) * ONE &&
            py < longint'(HEIGHT) * ONE && pz < longint'(SIZE_Z) * ONE) begin
          done = 1'b0;
          for (k = 0; k < MAX_STEPS && !done; k++) begin
            t   = longint'(k) * STEP_Q16;
            prx = vx;
            pry = vy;
            prz = vz;
            vx  = (px + ((t * dx) >>> FRAC_BITS)) >>> FRAC_BITS;
            vy  = (py + ((t * dy) >>> FRAC_BITS)) >>> FRAC_BITS;
            vz  = (pz + ((t * dz) >>> FRAC_BITS)) >>> FRAC_BITS;
            if (!in_bounds(vx, vy, vz)) begin
              done = 1'b1;
            end else if (grid_model[cell_of(vx, vy, vz)] != '0) begin
              // placing a solid block goes into the cell visited before the hit
              if (s.blk_code != '0) begin
                vx = prx;
                vy = pry;
                vz = prz;
              end
              grid_model[cell_of(vx, vy, vz)] = s.blk_code;
              r.wr = 1'b1;
              r.x  = vx[EX_W-1:0];
              r.y  = vy[EY_W-1:0];
              r.z  = vz[EZ_W-1:0];
              done = 1'b1;
            end
          end
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic add_row(cmd_e c, int bt, int px, int py, int pz, int dx, int dy, int dz,
                         bit typed = 1'b0, int rv = 0, int wr = 0,
                         int ex = 0, int ey = 0, int ez = 0);
    stim_t s;
    s.command    = c;
    s.blk_code   = TYPE_W'(bt);
    s.pos_x      = pos_t'(px);
    s.pos_y      = pos_t'(py);
    s.pos_z      = pos_t'(pz);
    s.dir_x      = dir_t'(dx);
    s.dir_y      = dir_t'(dy);
    s.dir_z      = dir_t'(dz);
    s.typed      = typed;
    s.want.rv    = TYPE_W'(rv);
    s.want.wr    = wr[0];
    s.want.x     = EX_W'(ex);
    s.want.y     = EY_W'(ey);
    s.want.z     = EZ_W'(ez);
    directed_rows.push_back(s);
  endtask

  function automatic stim_t random_item();
    stim_t s;
    spot_t tgt;
    int    pick, sx, sy, sz, qx, qy, qz;
    pick         = $urandom_range(0, 99);
    s.typed      = 1'b0;
    s.want       = '0;
    s.command    = CMD_NONE;
    s.blk_code   = TYPE_W'($urandom);
    s.pos_x      = pos_t'($urandom);
    s.pos_y      = pos_t'($urandom);
    s.pos_z      = pos_t'($urandom);
    s.dir_x      = dir_t'($urandom);
    s.dir_y      = dir_t'($urandom);
    s.dir_z      = dir_t'($urandom);
    if (pick < 30) begin
      s.command = CMD_WRITE;
      if ($urandom_range(0, 4) == 0) begin
        tgt.x = $urandom_range(0, SIZE_X - 1);
        tgt.y = $urandom_range(0, HEIGHT - 1);
        tgt.z = $urandom_range(0, SIZE_Z - 1);
      end else begin
        tgt.x = REG_LO + $urandom_range(0, REG_SPAN - 1);
        tgt.y = REG_LO / 2 + $urandom_range(0, REG_SPAN - 1);
        tgt.z = REG_LO + $urandom_range(0, REG_SPAN - 1);
      end
      s.blk_code = ($urandom_range(0, 9) == 0) ? '0 : TYPE_W'($urandom_range(1, 255));
      s.pos_x = pos_t'(tgt.x * ONE + int'($urandom_range(0, ONE - 1)));
      s.pos_y = pos_t'(tgt.y * ONE + int'($urandom_range(0, ONE - 1)));
      s.pos_z = pos_t'(tgt.z * ONE + int'($urandom_range(0, ONE - 1)));
      if (s.blk_code != '0) placed_blocks.push_back(tgt);
    end else if (pick < 45) begin
      s.command = CMD_READ;
      if ($urandom_range(0, 9) < 7 && placed_blocks.size() > 0) begin
        tgt = placed_blocks[$urandom_range(0, placed_blocks.size() - 1)];
        s.pos_x = pos_t'(tgt.x * ONE + int'($urandom_range(0, ONE - 1)));
        s.pos_y = pos_t'(tgt.y * ONE + int'($urandom_range(0, ONE - 1)));
        s.pos_z = pos_t'(tgt.z * ONE + int'($urandom_range(0, ONE - 1)));
      end else begin
        s.pos_x = pos_t'(int'($urandom_range(0, SIZE_X * ONE - 1)));
        s.pos_y = pos_t'(int'($urandom_range(0, HEIGHT * ONE - 1)));
        s.pos_z = pos_t'(int'($urandom_range(0, SIZE_Z * ONE - 1)));
      end
    end else if (pick < 65 && placed_blocks.size() > 0) begin
      // ray from a few cells away aimed at a placed block, arriving near t = 4
      s.command = CMD_RAY;
      if ($urandom_range(0, 9) < 3) s.blk_code = '0;
      tgt = placed_blocks[$urandom_range(0, placed_blocks.size() - 1)];
      sx  = clamp(tgt.x + int'($urandom_range(0, 12)) - 6, 0, SIZE_X - 1);
      sy  = clamp(tgt.y + int'($urandom_range(0, 12)) - 6, 0, HEIGHT - 1);
      sz  = clamp(tgt.z + int'($urandom_range(0, 12)) - 6, 0, SIZE_Z - 1);
      qx  = sx * ONE + int'($urandom_range(0, ONE - 1));
      qy  = sy * ONE + int'($urandom_range(0, ONE - 1));
      qz  = sz * ONE + int'($urandom_range(0, ONE - 1));
      s.pos_x = pos_t'(qx);
      s.pos_y = pos_t'(qy);
      s.pos_z = pos_t'(qz);
      s.dir_x = dir_t'((tgt.x * ONE + HALF - qx) / 4);
      s.dir_y = dir_t'((tgt.y * ONE + HALF - qy) / 4);
      s.dir_z = dir_t'((tgt.z * ONE + HALF - qz) / 4);
    end else if (pick < 85) begin
      s.command = CMD_RAY;
      s.pos_x = pos_t'(int'($urandom_range(0, SIZE_X * ONE - 1)));
      s.pos_y = pos_t'(int'($urandom_range(0, HEIGHT * ONE - 1)));
      s.pos_z = pos_t'(int'($urandom_range(0, SIZE_Z * ONE - 1)));
    end else begin
      s.command = cmd_e'($urandom_range(0, 3));
    end
    return s;
  endfunction

  // one command beat; valid stays high into the next beat when no gap is drawn
  task automatic drive_beat(stim_t s);
    int   gap;
    res_t got;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= s.command;
    cmd_if.blk_code   <= s.blk_code;
    cmd_if.pos_x      <= s.pos_x;
    cmd_if.pos_y      <= s.pos_y;
    cmd_if.pos_z      <= s.pos_z;
    cmd_if.dir_x      <= s.dir_x;
    cmd_if.dir_y      <= s.dir_y;
    cmd_if.dir_z      <= s.dir_z;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    got = march_and_edit(s);
    pending_results.push_back(s.typed ? s.want : got);
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // result side
  initial begin
    int   gap;
    res_t want;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(snk_calm);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        compare_field("read_value", want.rv, res_if.read_value);
        compare_field("wrote", 8'(want.wr), 8'(res_if.wrote));
        compare_field("edit_x", 8'(want.x), 8'(res_if.edit_x));
        compare_field("edit_y", 8'(want.y), 8'(res_if.edit_y));
        compare_field("edit_z", 8'(want.z), 8'(res_if.edit_z));
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int i;
    err_cnt  = 0;
    src_calm = 0;
    snk_calm = 0;
    for (i = 0; i < GRID_CELLS; i++) grid_model[i] = '0;
    rst_ni            <= 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= CMD_NONE;
    cmd_if.blk_code   <= '0;
    cmd_if.pos_x      <= '0;
    cmd_if.pos_y      <= '0;
    cmd_if.pos_z      <= '0;
    cmd_if.dir_x      <= '0;
    cmd_if.dir_y      <= '0;
    cmd_if.dir_z      <= '0;

    // fresh grid reads air at both corners, then a write to the far corner reads back
    add_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    add_row(CMD_READ, 0, 127 * ONE + ONE - 1, 63 * ONE + ONE - 1, 127 * ONE + ONE - 1,
            0, 0, 0, 1'b1, 0, 0, 127, 63, 127);
    add_row(CMD_WRITE, 255, 127 * ONE + ONE - 1, 63 * ONE + ONE - 1, 127 * ONE + ONE - 1,
            0, 0, 0, 1'b1, 0, 1, 127, 63, 127);
    add_row(CMD_READ, 0, 127 * ONE, 63 * ONE, 127 * ONE, 0, 0, 0, 1'b1, 255, 0, 127, 63, 127);
    // writes and reads outside the grid, and an unused command, do nothing
    add_row(CMD_WRITE, 8'hAA, -1, 5 * ONE, 5 * ONE, 0, 0, 0, 1'b1);
    add_row(CMD_WRITE, 1, SIZE_X * ONE, 5 * ONE, 5 * ONE, 0, 0, 0, 1'b1);
    add_row(CMD_READ, 0, 5 * ONE, HEIGHT * ONE, 5 * ONE, 0, 0, 0, 1'b1);
    add_row(CMD_READ, 0, POS_MAX, POS_MIN, POS_MAX, 0, 0, 0, 1'b1);
    add_row(CMD_NONE, 255, POS_MAX, POS_MAX, POS_MAX, DIR_MAX, DIR_MAX, DIR_MAX, 1'b1);
    // rays starting outside, and a ray that never meets a block
    add_row(CMD_RAY, 4, -1, 5 * ONE, 5 * ONE, ONE, 0, 0, 1'b1);
    add_row(CMD_RAY, 4, 5 * ONE, 5 * ONE, SIZE_Z * ONE, 0, 0, -ONE, 1'b1);
    add_row(CMD_RAY, 4, 5 * ONE + HALF, 5 * ONE + HALF, 5 * ONE + HALF, 0, 0, 0, 1'b1);
    // hit on the very first step overwrites the start cell itself
    add_row(CMD_WRITE, 7, 10 * ONE, 10 * ONE, 10 * ONE, 0, 0, 0, 1'b1, 0, 1, 10, 10, 10);
    add_row(CMD_RAY, 9, 10 * ONE + HALF, 10 * ONE + HALF, 10 * ONE + HALF, 1000, -1000, 500,
            1'b1, 0, 1, 10, 10, 10);
    add_row(CMD_READ, 0, 10 * ONE, 10 * ONE, 10 * ONE, 0, 0, 0, 1'b1, 9, 0, 10, 10, 10);
    // air removes the hit cell
    add_row(CMD_RAY, 0, 10 * ONE + HALF, 10 * ONE + HALF, 10 * ONE + HALF, 0, 0, 0,
            1'b1, 0, 1, 10, 10, 10);
    add_row(CMD_READ, 0, 10 * ONE, 10 * ONE, 10 * ONE, 0, 0, 0, 1'b1, 0, 0, 10, 10, 10);
    // place against a block down the x axis, then dig it back out
    add_row(CMD_WRITE, 3, 20 * ONE, 10 * ONE, 10 * ONE, 0, 0, 0, 1'b1, 0, 1, 20, 10, 10);
    add_row(CMD_RAY, 5, 15 * ONE + HALF, 10 * ONE + HALF, 10 * ONE + HALF, ONE, 0, 0);
    add_row(CMD_RAY, 0, 15 * ONE + HALF, 10 * ONE + HALF, 10 * ONE + HALF, ONE, 0, 0);
    // ray walking off the low x face, then rays from the centre at full-scale directions
    add_row(CMD_RAY, 6, ONE + HALF, ONE + HALF, ONE + HALF, DIR_MIN, 0, 0, 1'b1);
    add_row(CMD_RAY, 6, 64 * ONE + HALF, 32 * ONE + HALF, 64 * ONE + HALF,
            DIR_MAX, DIR_MAX, DIR_MAX);
    add_row(CMD_RAY, 6, 64 * ONE + HALF, 32 * ONE + HALF, 64 * ONE + HALF,
            DIR_MIN, DIR_MIN, DIR_MIN);
    add_row(CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) drive_beat(directed_rows[i]);
    repeat (RAND_ITEMS) drive_beat(random_item());
    cmd_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
